// ===== design/bmpd_pkg.sv =====
package bmpd_pkg;

    // Width of the image size registers and of the row and column counters.
    localparam int DIM_W = 13;
    localparam int DIM_MAX = (2 ** DIM_W) - 1;
    // Byte position within a stored row (up to three bytes per pixel).
    localparam int BYTE_CNT_W = DIM_W + 2;
    // Product of destination row and image width.
    localparam int IDX_PROD_W = 2 * DIM_W;
    localparam int IDX_W = 24;

    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_PALETTE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PIXEL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START   = 2'd2;

    localparam int REG_INDEX_W = 3;
    localparam logic [REG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [REG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [REG_INDEX_W-1:0] REG_DEPTH_MODE   = 3'd2;
    localparam logic [REG_INDEX_W-1:0] REG_GRAY_OUT     = 3'd3;
    localparam logic [REG_INDEX_W-1:0] REG_BOTTOM_UP    = 3'd4;

    // Luma weights and the reciprocal used for the divide by 1000.
    // The quotient is exact for every sum up to 255 * 1000 + 500.
    localparam int LUMA_SUM_W = 18;
    localparam int LUMA_RECIP_W = 19;
    localparam int LUMA_PROD_W = LUMA_SUM_W + LUMA_RECIP_W;
    localparam int LUMA_SHIFT = 28;
    localparam logic [LUMA_SUM_W-1:0] LUMA_WEIGHT_R = 18'd299;
    localparam logic [LUMA_SUM_W-1:0] LUMA_WEIGHT_G = 18'd587;
    localparam logic [LUMA_SUM_W-1:0] LUMA_WEIGHT_B = 18'd114;
    localparam logic [LUMA_SUM_W-1:0] LUMA_ROUND    = 18'd500;
    localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP =
        LUMA_RECIP_W'(((2 ** LUMA_SHIFT) + 999) / 1000);

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [7:0]       palette_index;
        logic [31:0]      palette_word;
        logic [7:0]       data_byte;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] pixel_index;
        logic [31:0]      pixel_value;
        logic             last_pixel;
    } out_item_t;

    typedef struct packed {
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic             depth_mode;
        logic             gray_out;
        logic             bottom_up;
    } config_t;

    // What the byte sequencer hands to the color pipeline for one pixel.
    typedef struct packed {
        logic [DIM_W-1:0] drow;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] width;
        logic             last;
        logic             depth;
        logic             gray;
        logic             pal_ok;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } pix_ctl_t;

endpackage

// ===== design/bmpd_if.sv =====
interface bmpd_in_if;
    import bmpd_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bmpd_out_if;
    import bmpd_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bmpd_cfg_if;
    import bmpd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [REG_INDEX_W-1:0] reg_index;
    logic [DIM_W-1:0]       reg_data;
    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

// ===== design/bmpd_ram.sv =====
module bmpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/bmpd_ctrl.sv =====
module bmpd_ctrl #(
    parameter int PAL_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bmpd_pkg::config_t  cfg_regs,
    input  logic               accept,
    input  bmpd_pkg::in_item_t item,
    output logic               emit,
    output bmpd_pkg::pix_ctl_t ctl
);
    import bmpd_pkg::*;

    logic [DIM_W-1:0]      col_reg, col_next;
    logic [DIM_W-1:0]      row_reg, row_next;
    logic [BYTE_CNT_W-1:0] rbc_reg, rbc_next;
    logic [1:0]            phase_reg, phase_next;
    logic [15:0]           held_reg, held_next;

    logic [BYTE_CNT_W-1:0] width_ext;
    logic [BYTE_CNT_W-1:0] data_bytes;
    logic [BYTE_CNT_W-1:0] padded;
    logic [BYTE_CNT_W:0]   rbc_inc;
    logic                  is_byte;
    logic                  in_data;
    logic                  row_done;

    assign width_ext  = BYTE_CNT_W'(cfg_regs.image_width);
    assign data_bytes = cfg_regs.depth_mode ? (width_ext + (width_ext << 1)) : width_ext;
    assign padded     = (data_bytes + BYTE_CNT_W'(3)) & ~BYTE_CNT_W'(3);

    assign is_byte  = accept && (item.cmd == CMD_PIXEL) && (row_reg < cfg_regs.image_height);
    assign in_data  = (rbc_reg < data_bytes) && (col_reg < cfg_regs.image_width);
    assign emit     = is_byte && in_data && (!cfg_regs.depth_mode || (phase_reg == 2'd2));
    assign rbc_inc  = {1'b0, rbc_reg} + (BYTE_CNT_W + 1)'(1);
    assign row_done = rbc_inc >= {1'b0, padded};

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        rbc_next   = rbc_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        if (accept && (item.cmd == CMD_START))
        begin
            col_next   = '0;
            row_next   = '0;
            rbc_next   = '0;
            phase_next = '0;
            held_next  = '0;
        end
        else if (is_byte)
        begin
            if (in_data && cfg_regs.depth_mode)
            begin
                unique case (phase_reg)
                    2'd0:
                    begin
                        held_next  = {8'h00, item.data_byte};
                        phase_next = 2'd1;
                    end
                    2'd1:
                    begin
                        held_next  = {item.data_byte, held_reg[7:0]};
                        phase_next = 2'd2;
                    end
                    default:
                    begin
                        phase_next = 2'd0;
                    end
                endcase
            end
            if (emit)
            begin
                col_next = col_reg + DIM_W'(1);
            end
            if (row_done)
            begin
                rbc_next   = '0;
                col_next   = '0;
                phase_next = '0;
                row_next   = row_reg + DIM_W'(1);
            end
            else
            begin
                rbc_next = rbc_inc[BYTE_CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            rbc_reg   <= '0;
            phase_reg <= '0;
            held_reg  <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            rbc_reg   <= rbc_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    always_comb
    begin
        ctl.drow   = cfg_regs.bottom_up ?
                     (cfg_regs.image_height - DIM_W'(1) - row_reg) : row_reg;
        ctl.col    = col_reg;
        ctl.width  = cfg_regs.image_width;
        ctl.last   = ((col_reg + DIM_W'(1)) == cfg_regs.image_width) &&
                     ((row_reg + DIM_W'(1)) == cfg_regs.image_height);
        ctl.depth  = cfg_regs.depth_mode;
        ctl.gray   = cfg_regs.gray_out;
        ctl.pal_ok = {1'b0, item.data_byte} < 9'(PAL_DEPTH);
        ctl.red    = item.data_byte;
        ctl.green  = held_reg[15:8];
        ctl.blue   = held_reg[7:0];
    end

endmodule

// ===== design/bmpd_color.sv =====
module bmpd_color (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  bmpd_pkg::pix_ctl_t  ctl,
    input  logic [31:0]         pal_q,
    output logic                take,
    output logic                out_valid,
    input  logic                out_ready,
    output bmpd_pkg::out_item_t out_item
);
    import bmpd_pkg::*;

    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;

    pix_ctl_t ctl1_reg;
    logic [31:0] color1;

    logic [LUMA_SUM_W-1:0] pr2_reg, pg2_reg, pb2_reg;
    logic [31:0]           color2_reg;
    logic                  gray2_reg;
    logic                  last2_reg;
    logic [IDX_PROD_W-1:0] prod2_reg;
    logic [DIM_W-1:0]      col2_reg;

    logic [LUMA_SUM_W-1:0]  luma_sum;
    logic [LUMA_PROD_W-1:0] luma_prod;
    logic [IDX_PROD_W-1:0]  idx_full;
    out_item_t              out_reg;

    assign en3  = !v3_reg || out_ready;
    assign en2  = !v2_reg || en3;
    assign en1  = !v1_reg || en2;
    assign take = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= load;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Palette data lines up with the first stage register.
    assign color1 = ctl1_reg.depth ? {8'h00, ctl1_reg.red, ctl1_reg.green, ctl1_reg.blue}
                  : (ctl1_reg.pal_ok ? pal_q : 32'h0);

    assign luma_sum  = pr2_reg + pg2_reg + pb2_reg + LUMA_ROUND;
    assign luma_prod = LUMA_PROD_W'(luma_sum) * LUMA_PROD_W'(LUMA_RECIP);
    assign idx_full  = prod2_reg + IDX_PROD_W'(col2_reg);

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ctl1_reg <= ctl;
        end
        if (en2)
        begin
            pr2_reg    <= LUMA_SUM_W'(color1[23:16]) * LUMA_WEIGHT_R;
            pg2_reg    <= LUMA_SUM_W'(color1[15:8]) * LUMA_WEIGHT_G;
            pb2_reg    <= LUMA_SUM_W'(color1[7:0]) * LUMA_WEIGHT_B;
            color2_reg <= color1;
            gray2_reg  <= ctl1_reg.gray;
            last2_reg  <= ctl1_reg.last;
            prod2_reg  <= IDX_PROD_W'(ctl1_reg.drow) * IDX_PROD_W'(ctl1_reg.width);
            col2_reg   <= ctl1_reg.col;
        end
        if (en3)
        begin
            out_reg.pixel_index <= idx_full[IDX_W-1:0];
            out_reg.pixel_value <= gray2_reg ?
                {24'h0, luma_prod[LUMA_SHIFT+7:LUMA_SHIFT]} : color2_reg;
            out_reg.last_pixel  <= last2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = out_reg;

endmodule

// ===== design/bmp_pixel_array_decoder.sv =====
// Channel   Modport  Beat carries                                   Accepted when
// pix_in    sink     cmd, palette_index, palette_word, data_byte    valid && ready
// pix_out   source   pixel_index, pixel_value, last_pixel           valid && ready
// cfg       sink     reg_index, reg_data                            valid && ready
//
// One input beat is taken per cycle while the pipeline is not full and stalled. A pixel
// result passes through the palette read, the luma and index products, then the divide
// by 1000 and the index add into the output register.
// rst_n clears the row, column, byte and triple counters and the pipeline valid bits;
// the configuration registers return to width 1, height 1, 8-bit, color, bottom-up.
// The palette memory is not cleared; entries must be written before they are used.
// Each pipeline stage holds its beat only while the stage after it is full and stalled,
// so input keeps flowing while a finished pixel waits on pix_out, until all stages are full.
module bmp_pixel_array_decoder #(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    bmpd_in_if.sink           pix_in,
    bmpd_out_if.source        pix_out,
    bmpd_cfg_if.sink          cfg
);
    import bmpd_pkg::*;

    localparam int PAL_AW = $clog2(PALETTE_DEPTH);
    localparam int WIDTH_LIM_I  = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
    localparam int HEIGHT_LIM_I = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
    localparam logic [DIM_W-1:0] WIDTH_LIM  = DIM_W'(WIDTH_LIM_I);
    localparam logic [DIM_W-1:0] HEIGHT_LIM = DIM_W'(HEIGHT_LIM_I);

    config_t  cfg_reg;
    logic     cfg_wr;
    logic     accept;
    logic     emit;
    pix_ctl_t ctl;
    logic     take;
    logic     pal_we;
    logic [31:0] pal_q;
    logic [DIM_W-1:0] size_data;
    logic [DIM_W-1:0] width_clamped;
    logic [DIM_W-1:0] height_clamped;

    // Configuration registers. Sizes are forced into the legal range on write.
    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign size_data = (cfg.reg_data == '0) ? DIM_W'(1) : cfg.reg_data;
    assign width_clamped  = (size_data > WIDTH_LIM) ? WIDTH_LIM : size_data;
    assign height_clamped = (size_data > HEIGHT_LIM) ? HEIGHT_LIM : size_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= DIM_W'(1);
            cfg_reg.image_height <= DIM_W'(1);
            cfg_reg.depth_mode   <= 1'b0;
            cfg_reg.gray_out     <= 1'b0;
            cfg_reg.bottom_up    <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (cfg.reg_index)
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= width_clamped;
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= height_clamped;
                REG_DEPTH_MODE:   cfg_reg.depth_mode   <= cfg.reg_data[0];
                REG_GRAY_OUT:     cfg_reg.gray_out     <= cfg.reg_data[0];
                REG_BOTTOM_UP:    cfg_reg.bottom_up    <= cfg.reg_data[0];
                default:          ;
            endcase
        end
    end

    // Input side: the sequencer walks rows, padding and BGR triples and decides
    // which beats produce a pixel.
    assign pix_in.ready = take;
    assign accept       = pix_in.valid && take;

    bmpd_ctrl #(
        .PAL_DEPTH (PALETTE_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_reg),
        .accept   (accept),
        .item     (pix_in.payload),
        .emit     (emit),
        .ctl      (ctl)
    );

    // Palette memory. Every accepted beat also issues a read, yet a palette write
    // followed by a read of the same entry on the next beat already sees new data.
    assign pal_we = accept && (pix_in.payload.cmd == CMD_PALETTE) &&
                    ({1'b0, pix_in.payload.palette_index} < 9'(PALETTE_DEPTH));

    bmpd_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_we),
        .wr_addr (pix_in.payload.palette_index[PAL_AW-1:0]),
        .wr_data (pix_in.payload.palette_word),
        .rd_en   (take),
        .rd_addr (pix_in.payload.data_byte[PAL_AW-1:0]),
        .rd_data (pal_q)
    );

    // Color pipeline: palette lookup or BGR assembly, luma, destination index.
    bmpd_color u_color (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .ctl       (ctl),
        .pal_q     (pal_q),
        .take      (take),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .out_item  (pix_out.payload)
    );

    // An empty output register must never hold back the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pix_out.valid |-> pix_in.ready)
        else $error("input stalled while output register is empty");

    // A palette write comes only from an accepted beat and never produces a pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        pal_we |-> (accept && !emit))
        else $error("palette write outside an accepted palette beat");

    // A pixel enters the pipeline only in a cycle that also issues its palette read.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (accept && take))
        else $error("pixel issued without a palette read");

endmodule

// ===== test/tb_bmp_pixel_array_decoder.sv =====
module tb_bmp_pixel_array_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import bmpd_pkg::*;

    // Sizes the block is built with; the predictor saturates against the same limits.
    localparam int MAX_W = 4096;
    localparam int MAX_H = 4096;
    localparam int PAL_DEPTH = 256;

    // The one command code the package leaves unnamed; the block must ignore it.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Cycles to let pass once nothing is expected, so that a beat that made no
    // pixel has surely left the three-stage pipeline before the next register write.
    localparam int DRAIN_CYCLES = 8;
    // Cycles without any accepted beat on any channel before the run is called hung.
    localparam int STALL_LIMIT = 4000;
    // Length of the deliberate hold-off on the result channel.
    localparam int LONG_HOLD = 300;
    // Random beats per idling phase.
    localparam int BEATS_PER_PHASE = 175;

    logic clk = 1'b0;
    logic rst_n;

    bmpd_in_if  pix_in ();
    bmpd_out_if pix_out ();
    bmpd_cfg_if cfg ();

    bmp_pixel_array_decoder #(
        .MAX_WIDTH     (MAX_W),
        .MAX_HEIGHT    (MAX_H),
        .PALETTE_DEPTH (PAL_DEPTH)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .cfg     (cfg)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder predictor state. It mirrors the block's registers, counters and
    // palette and is advanced once per accepted beat, in acceptance order.
    // ------------------------------------------------------------------
    logic [31:0] pal_mem [PAL_DEPTH] = '{default: '0};
    int          col_cnt = 0;
    int          row_cnt = 0;
    int          row_byte = 0;
    int          triple_pos = 0;
    logic [15:0] held_bg = '0;

    int   img_width;
    int   img_height;
    logic depth_24;
    logic gray_on;
    logic bottom_up;

    // Pixels the block still owes us, oldest first.
    out_item_t expected_pixels [$];

    // Beats waiting for the driver, filled by the stimulus process.
    in_item_t pending_beats [$];

    // Palette entries that the stimulus has loaded; only these may be indexed.
    logic [7:0] loaded_idx [$];
    bit         pal_loaded [PAL_DEPTH];

    int  stim_count;
    int  mismatches = 0;
    int  send_idle_pct;
    int  recv_stall_pct;
    // Toggled by the stimulus to ask the receiver for one long hold-off.
    bit  hold_req;

    function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int lim);
        if (v == '0)
            return 1;
        if (int'(v) > lim)
            return lim;
        return int'(v);
    endfunction

    // Bytes in one stored row, padding to a four-byte boundary included.
    function automatic int padded_row_bytes();
        int bits_per_row;
        bits_per_row = (depth_24 ? 24 : 8) * img_width;
        return ((bits_per_row + 31) >> 5) << 2;
    endfunction

    function automatic logic [7:0] luma8(input logic [7:0] b, input logic [7:0] g,
                                         input logic [7:0] r);
        int sum;
        sum = int'(LUMA_WEIGHT_R) * int'(r) + int'(LUMA_WEIGHT_G) * int'(g)
            + int'(LUMA_WEIGHT_B) * int'(b) + int'(LUMA_ROUND);
        return 8'(sum / 1000);
    endfunction

    function automatic void restart_frame();
        col_cnt    = 0;
        row_cnt    = 0;
        row_byte   = 0;
        triple_pos = 0;
        held_bg    = '0;
    endfunction

    function automatic void load_reg(input logic [REG_INDEX_W-1:0] idx,
                                     input logic [DIM_W-1:0] data);
        case (idx)
            REG_IMAGE_WIDTH:  img_width  = clamp_dim(data, MAX_W);
            REG_IMAGE_HEIGHT: img_height = clamp_dim(data, MAX_H);
            REG_DEPTH_MODE:   depth_24   = data[0];
            REG_GRAY_OUT:     gray_on    = data[0];
            REG_BOTTOM_UP:    bottom_up  = data[0];
            default: ;
        endcase
    endfunction

    // Advances the decoder state by one beat and queues the pixel it yields, if any.
    function automatic void decode_beat(input in_item_t b);
        int          data_bytes;
        int          row_size;
        int          drow;
        logic [31:0] word;
        logic [31:0] color;
        out_item_t   px;
        bit          emit;
        emit  = 1'b0;
        color = '0;
        case (b.cmd)
            CMD_PALETTE: pal_mem[b.palette_index] = b.palette_word;
            CMD_START:   restart_frame();
            CMD_PIXEL:
            begin
                // Once the last row is done, bytes are dropped until the next start.
                if (row_cnt < img_height)
                begin
                    data_bytes = img_width * (depth_24 ? 3 : 1);
                    row_size   = padded_row_bytes();
                    if (row_byte < data_bytes && col_cnt < img_width)
                    begin
                        if (!depth_24)
                        begin
                            word  = pal_mem[b.data_byte];
                            color = gray_on ? {24'd0, luma8(word[7:0], word[15:8], word[23:16])}
                                            : word;
                            emit  = 1'b1;
                        end
                        else if (triple_pos == 0)
                        begin
                            held_bg    = {8'd0, b.data_byte};
                            triple_pos = 1;
                        end
                        else if (triple_pos == 1)
                        begin
                            held_bg[15:8] = b.data_byte;
                            triple_pos    = 2;
                        end
                        else
                        begin
                            color = gray_on ? {24'd0, luma8(held_bg[7:0], held_bg[15:8], b.data_byte)}
                                            : {8'd0, b.data_byte, held_bg[15:8], held_bg[7:0]};
                            triple_pos = 0;
                            emit       = 1'b1;
                        end
                    end
                    if (emit)
                    begin
                        drow = bottom_up ? img_height - 1 - row_cnt : row_cnt;
                        px.pixel_index = IDX_W'(drow * img_width + col_cnt);
                        px.pixel_value = color;
                        px.last_pixel  = (col_cnt + 1 == img_width) && (row_cnt + 1 == img_height);
                        expected_pixels.push_back(px);
                        col_cnt++;
                    end
                    row_byte++;
                    if (row_byte >= row_size)
                    begin
                        row_byte   = 0;
                        col_cnt    = 0;
                        triple_pos = 0;
                        row_cnt++;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued beats on pix_in. A beat stays on the bus until it
    // is taken; between beats the sender may idle according to the phase.
    // The prediction is made at the edge where the beat is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix_in.valid   <= 1'b0;
            pix_in.payload <= '0;
        end
        else
        begin
            if (pix_in.valid && pix_in.ready)
                decode_beat(pix_in.payload);
            if (pix_in.valid && !pix_in.ready)
            begin
                // Still waiting for the block to take the current beat.
            end
            else if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                pix_in.payload <= pending_beats.pop_front();
                pix_in.valid   <= 1'b1;
            end
            else
            begin
                pix_in.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and receiver: checks every accepted pixel beat against the oldest
    // expectation and drives pix_out.ready, including the long hold-off.
    // ------------------------------------------------------------------
    bit hold_seen = 1'b0;
    int hold_left = 0;

    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (!rst_n)
        begin
            pix_out.ready <= 1'b0;
        end
        else
        begin
            if (pix_out.valid && pix_out.ready)
            begin
                got = pix_out.payload;
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: pixel beat with none expected: index %h value %h last %b",
                             $time, got.pixel_index, got.pixel_value, got.last_pixel);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.pixel_index !== want.pixel_index)
                    begin
                        mismatches++;
                        $display("%0t ns: pixel_index expected %h got %h",
                                 $time, want.pixel_index, got.pixel_index);
                    end
                    if (got.pixel_value !== want.pixel_value)
                    begin
                        mismatches++;
                        $display("%0t ns: pixel_value expected %h got %h",
                                 $time, want.pixel_value, got.pixel_value);
                    end
                    if (got.last_pixel !== want.last_pixel)
                    begin
                        mismatches++;
                        $display("%0t ns: last_pixel expected %b got %b",
                                 $time, want.last_pixel, got.last_pixel);
                    end
                end
            end
            if (hold_seen != hold_req)
            begin
                // A long hold-off was asked for: keep ready low for a fixed stretch
                // so the pipeline fills and pushes back on the input side.
                hold_seen     <= hold_req;
                hold_left     <= LONG_HOLD;
                pix_out.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                pix_out.ready <= 1'b0;
            end
            else
            begin
                pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: the run is hung if no channel moves a beat for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        do
        begin
            @(posedge clk);
            if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)
                || (cfg.valid && cfg.ready))
                quiet = 0;
            else
                quiet++;
        end
        while (quiet < STALL_LIMIT);
        $display("tb_bmp_pixel_array_decoder failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. They run in the stimulus process and only fill the
    // beat queue or drive the register channel.
    // ------------------------------------------------------------------
    function automatic in_item_t make_beat(input logic [CMD_W-1:0] c, input logic [7:0] db);
        in_item_t b;
        b.cmd           = c;
        b.palette_index = 8'($urandom);
        b.palette_word  = $urandom;
        b.data_byte     = db;
        return b;
    endfunction

    function automatic void push_beat(input in_item_t b);
        pending_beats.push_back(b);
        if (b.cmd != CMD_UNUSED)
            stim_count++;
    endfunction

    function automatic void palette_load(input logic [7:0] idx, input logic [31:0] word);
        in_item_t b;
        b = make_beat(CMD_PALETTE, 8'($urandom));
        b.palette_index = idx;
        b.palette_word  = word;
        push_beat(b);
        if (!pal_loaded[idx])
        begin
            pal_loaded[idx] = 1'b1;
            loaded_idx.push_back(idx);
        end
    endfunction

    // In palette mode every pixel byte, padding included, names a loaded entry,
    // so no pixel is colored from palette memory that was not written.
    function automatic logic [7:0] next_data_byte();
        if (depth_24)
            return 8'($urandom);
        return loaded_idx[$urandom_range(loaded_idx.size() - 1)];
    endfunction

    function automatic void push_pixel(input logic [7:0] db);
        push_beat(make_beat(CMD_PIXEL, db));
    endfunction

    // Waits until every queued beat is taken and every pixel has come back,
    // then lets the pipeline empty of beats that made no pixel.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_beats.size() != 0 || pix_in.valid || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_INDEX_W-1:0] idx, input logic [DIM_W-1:0] data);
        cfg.valid     <= 1'b1;
        cfg.reg_index <= idx;
        cfg.reg_data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        load_reg(idx, data);
    endtask

    // Writes all five registers back to back once the block is idle.
    task automatic set_config(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic d, input logic g, input logic bu);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_DEPTH_MODE, DIM_W'(d));
        write_reg(REG_GRAY_OUT, DIM_W'(g));
        write_reg(REG_BOTTOM_UP, DIM_W'(bu));
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [DIM_W-1:0] pick_dim(input int small_max);
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return DIM_W'($urandom_range(small_max, 1));
        if (roll < 95)
            return DIM_W'($urandom_range(40, small_max + 1));
        // Extremes: zero saturates to one, the all-ones code to the maximum.
        case ($urandom_range(3))
            0:       return '0;
            1:       return DIM_W'(MAX_W - 1);
            2:       return DIM_W'(MAX_W);
            default: return '1;
        endcase
    endfunction

    // One image with random settings and content. Most are whole images; some
    // are cut short, run past the end, skip the start command or carry noise.
    task automatic random_image();
        int total;
        int n_send;
        int roll;
        int i;
        set_config(pick_dim(9), pick_dim(5), 1'($urandom), 1'($urandom), 1'($urandom));
        if (!depth_24 && $urandom_range(2) == 0)
            repeat ($urandom_range(8, 2))
                palette_load(8'($urandom), $urandom);
        if ($urandom_range(99) < 85)
            push_beat(make_beat(CMD_START, 8'($urandom)));
        total = img_height * padded_row_bytes();
        // Huge images are only sampled; when bottom-up, their first rows still use the far indexes.
        n_send = (total > 150) ? $urandom_range(80, 20) : total;
        roll = $urandom_range(99);
        if (roll < 10)
            n_send = $urandom_range(n_send, 1);
        else if (roll < 20)
            n_send += $urandom_range(4, 1);
        for (i = 0; i < n_send; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 2)
                push_beat(make_beat(CMD_UNUSED, 8'($urandom)));
            else if (roll < 4)
                palette_load(8'($urandom), $urandom);
            else if (roll < 6 && i == n_send / 2)
                wait_drained();
            push_pixel(next_data_byte());
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed cases, then four idling phases of random images.
    // ------------------------------------------------------------------
    initial
    begin
        int ph;
        int goal;
        int i;

        rst_n = 1'b0;
        cfg.valid       <= 1'b0;
        cfg.reg_index   <= REG_IMAGE_WIDTH;
        cfg.reg_data    <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        stim_count     = 0;
        for (i = 0; i < PAL_DEPTH; i++)
        begin
            pal_loaded[i] = 1'b0;
        end
        img_width  = 1;
        img_height = 1;
        depth_24   = 1'b0;
        gray_on    = 1'b0;
        bottom_up  = 1'b1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Palette extremes; the alpha byte of entry zero must pass through
        // in color and be ignored in gray.
        palette_load(8'hFF, 32'hFFFF_FFFF);
        palette_load(8'h00, 32'hFF00_0000);
        palette_load(8'h5A, $urandom);

        // Right after reset, without a start command: a 1x1 palette image,
        // three padding bytes, one byte past the image, and an unused command.
        push_pixel(8'h00);
        repeat (3) push_pixel(8'hFF);
        push_pixel(8'h5A);
        push_beat(make_beat(CMD_UNUSED, 8'hFF));

        // Width beyond range saturates to the maximum; bottom-up at full height
        // gives the largest destination indexes. Gray output from the palette.
        set_config('1, DIM_W'(MAX_H), 1'b0, 1'b1, 1'b1);
        push_beat(make_beat(CMD_START, 8'h00));
        push_pixel(8'hFF);
        push_pixel(8'h00);
        push_pixel(8'h5A);

        // Settings change in the middle of a row: width zero saturates to one,
        // so the next byte closes the row, then a 24-bit color pixel top-down.
        set_config('0, '1, 1'b1, 1'b0, 1'b0);
        push_pixel(8'h00);
        push_pixel(8'h12);
        push_pixel(8'hED);
        push_pixel(8'h80);

        // 24-bit gray at both ends of the range, with the last-pixel flag.
        set_config(DIM_W'(1), DIM_W'(2), 1'b1, 1'b1, 1'b0);
        push_beat(make_beat(CMD_START, 8'hFF));
        repeat (3) push_pixel(8'hFF);
        push_pixel(8'h00);
        repeat (3) push_pixel(8'h00);
        push_pixel(8'hFF);

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 81;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 81;
                end
                default:
                begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
            endcase
            goal = stim_count + BEATS_PER_PHASE;
            if (ph == 0)
            begin
                // Back-pressure case: a long palette image is offered at full rate
                // while the receiver holds off, so the block must stall its input.
                set_config(DIM_W'(40), DIM_W'(3), 1'b0, 1'($urandom), 1'($urandom));
                repeat (4) palette_load(8'($urandom), $urandom);
                hold_req = ~hold_req;
                push_beat(make_beat(CMD_START, 8'($urandom)));
                repeat (120) push_pixel(next_data_byte());
            end
            while (stim_count < goal)
                random_image();
        end

        wait_drained();
        if (mismatches == 0)
            $display("tb_bmp_pixel_array_decoder passed");
        else
            $display("tb_bmp_pixel_array_decoder failed");
        $finish;
    end

endmodule
